// ----- sv/assert_macros.svh -----
// assertion macros used by the sprite motion pipeline top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked only out of reset
`define SBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SBM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBM_ASSERT(lbl, prop, msg)
`define SBM_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- sv/sbm_pkg.sv -----
// types, constants and register codes of the sprite motion pipeline
package sbm_pkg;

    localparam int ANGLE_WRAP = 36000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPDATE_ENABLE = 3'd0,
        CFG_DISP_W        = 3'd1,
        CFG_DISP_H        = 3'd2,
        CFG_ZOOM_MINIMUM  = 3'd3,
        CFG_ZOOM_MAXIMUM  = 3'd4
    } cfg_idx_t;

    localparam logic [15:0] ZOOM_BOUND_RESET = 16'd1024;

    typedef struct packed {
        logic        update_enable;
        logic [14:0] disp_w;
        logic [14:0] disp_h;
        logic [15:0] zoom_minimum;
        logic [15:0] zoom_maximum;
    } cfg_t;

    // fields that travel down the pipe and pass through untouched when not updated
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic        [15:0] ang;
        logic        [15:0] zm;
        logic signed [15:0] zr;
    } rec_t;

    typedef struct packed {
        logic [7:0]         resv;
        rec_t               rec;
        logic signed [15:0] ar;
        logic               last;
    } in_rec_t;

    // after the adders
    typedef struct packed {
        logic               go;
        logic               last;
        rec_t               rec;
        logic signed [17:0] sum_a;
        logic signed [16:0] sum_x;
        logic signed [16:0] sum_y;
        logic signed [17:0] sum_z;
    } s1_t;

    // after the compares
    typedef struct packed {
        logic        go;
        logic        last;
        rec_t        rec;
        logic [15:0] ang_new;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        x_lo;
        logic        x_hi;
        logic        y_lo;
        logic        y_hi;
        logic        z_lo;
        logic        z_hi;
        logic [14:0] hx;
        logic [14:0] hy;
        logic [15:0] zmin;
        logic [15:0] zmax;
    } s2_t;

    typedef struct packed {
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
        logic signed [15:0] new_vel_x;
        logic signed [15:0] new_vel_y;
        logic        [15:0] new_angle;
        logic        [15:0] new_zoom;
        logic signed [15:0] new_zoom_rate;
        logic               was_updated;
        logic               last_out;
    } res_t;

endpackage

// ----- sv/sbm_in_if.sv -----
// record input channel
interface sbm_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         reserved_byte;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [15:0]        angle;
    logic [15:0]        zoom;
    logic signed [15:0] angle_rate;
    logic signed [15:0] zoom_rate;
    logic               last_in_frame;

    modport source (
        output valid, reserved_byte, pos_x, pos_y, vel_x, vel_y, angle, zoom,
               angle_rate, zoom_rate, last_in_frame,
        input  ready
    );
    modport sink (
        input  valid, reserved_byte, pos_x, pos_y, vel_x, vel_y, angle, zoom,
               angle_rate, zoom_rate, last_in_frame,
        output ready
    );
endinterface

// ----- sv/sbm_out_if.sv -----
// result output channel
interface sbm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic signed [15:0] new_vel_x;
    logic signed [15:0] new_vel_y;
    logic [15:0]        new_angle;
    logic [15:0]        new_zoom;
    logic signed [15:0] new_zoom_rate;
    logic               was_updated;
    logic               last_out;

    modport source (
        output valid, new_x, new_y, new_vel_x, new_vel_y, new_angle, new_zoom,
               new_zoom_rate, was_updated, last_out,
        input  ready
    );
    modport sink (
        input  valid, new_x, new_y, new_vel_x, new_vel_y, new_angle, new_zoom,
               new_zoom_rate, was_updated, last_out,
        output ready
    );
endinterface

// ----- sv/sbm_sum_stage.sv -----
// stage 1: record check and the four adders
module sbm_sum_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  sbm_pkg::in_rec_t in_rec,
    input  sbm_pkg::cfg_t    cfg,
    output logic             s1_valid,
    output sbm_pkg::s1_t     s1
);
    import sbm_pkg::*;

    localparam logic [15:0] WRAP16 = 16'(ANGLE_WRAP);

    logic s1_valid_reg;
    s1_t  s1_reg;
    s1_t  s1_next;

    always_comb
    begin
        s1_next.go    = cfg.update_enable && (in_rec.resv == 8'd0) &&
                        (in_rec.rec.ang < WRAP16) && (in_rec.rec.zm != 16'd0);
        s1_next.last  = in_rec.last;
        s1_next.rec   = in_rec.rec;
        s1_next.sum_a = {2'b00, in_rec.rec.ang} + {{2{in_rec.ar[15]}}, in_rec.ar};
        s1_next.sum_x = {in_rec.rec.x[15], in_rec.rec.x} + {in_rec.rec.vx[15], in_rec.rec.vx};
        s1_next.sum_y = {in_rec.rec.y[15], in_rec.rec.y} + {in_rec.rec.vy[15], in_rec.rec.vy};
        s1_next.sum_z = {2'b00, in_rec.rec.zm} + {{2{in_rec.rec.zr[15]}}, in_rec.rec.zr};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;
endmodule

// ----- sv/sbm_cmp_stage.sv -----
// stage 2: angle wrap and bound compares
module sbm_cmp_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          s1_valid,
    input  sbm_pkg::s1_t  s1,
    input  sbm_pkg::cfg_t cfg,
    output logic          s2_valid,
    output sbm_pkg::s2_t  s2
);
    import sbm_pkg::*;

    localparam logic signed [17:0] WRAP18 = 18'(ANGLE_WRAP);

    logic               s2_valid_reg;
    s2_t                s2_reg;
    s2_t                s2_next;
    logic signed [17:0] ang_fix;

    always_comb
    begin
        // sum stays within one wrap of the range, so one correction is enough
        priority if (s1.sum_a < 18'sd0)
        begin
            ang_fix = s1.sum_a + WRAP18;
        end
        else if (s1.sum_a >= WRAP18)
        begin
            ang_fix = s1.sum_a - WRAP18;
        end
        else
        begin
            ang_fix = s1.sum_a;
        end

        s2_next.go      = s1.go;
        s2_next.last    = s1.last;
        s2_next.rec     = s1.rec;
        s2_next.ang_new = ang_fix[15:0];
        s2_next.nx      = s1.sum_x[15:0];
        s2_next.ny      = s1.sum_y[15:0];
        s2_next.nz      = s1.sum_z[15:0];
        s2_next.hx      = (cfg.disp_w == 15'd0) ? 15'd0 : cfg.disp_w - 15'd1;
        s2_next.hy      = (cfg.disp_h == 15'd0) ? 15'd0 : cfg.disp_h - 15'd1;
        s2_next.zmin    = cfg.zoom_minimum;
        s2_next.zmax    = cfg.zoom_maximum;
        s2_next.x_lo    = s1.sum_x[16];
        s2_next.x_hi    = s1.sum_x > $signed({2'b00, s2_next.hx});
        s2_next.y_lo    = s1.sum_y[16];
        s2_next.y_hi    = s1.sum_y > $signed({2'b00, s2_next.hy});
        s2_next.z_lo    = s1.sum_z < $signed({2'b00, cfg.zoom_minimum});
        s2_next.z_hi    = s1.sum_z > $signed({2'b00, cfg.zoom_maximum});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;
endmodule

// ----- sv/sbm_sel_stage.sv -----
// stage 3: bounce selection, rate reflection and the output register
module sbm_sel_stage (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         s2_valid,
    input  sbm_pkg::s2_t s2,
    output logic         res_valid,
    output sbm_pkg::res_t res
);
    import sbm_pkg::*;

    logic res_valid_reg;
    res_t res_reg;
    res_t res_next;

    // most negative rate saturates when made positive
    function automatic logic [15:0] abs_sat(input logic [15:0] r);
        logic [15:0] v;
        begin
            if (r == 16'h8000)
            begin
                v = 16'h7FFF;
            end
            else
            begin
                v = r[15] ? (16'd0 - r) : r;
            end
            return v;
        end
    endfunction

    function automatic logic [15:0] neg_abs(input logic [15:0] r);
        logic [15:0] v;
        begin
            v = (!r[15] && (r != 16'd0)) ? (16'd0 - r) : r;
            return v;
        end
    endfunction

    always_comb
    begin
        res_next.new_x         = s2.rec.x;
        res_next.new_y         = s2.rec.y;
        res_next.new_vel_x     = s2.rec.vx;
        res_next.new_vel_y     = s2.rec.vy;
        res_next.new_angle     = s2.rec.ang;
        res_next.new_zoom      = s2.rec.zm;
        res_next.new_zoom_rate = s2.rec.zr;
        res_next.was_updated   = s2.go;
        res_next.last_out      = s2.last;

        if (s2.go)
        begin
            res_next.new_angle = s2.ang_new;

            priority if (s2.x_lo)
            begin
                res_next.new_x     = 16'sd0;
                res_next.new_vel_x = abs_sat(s2.rec.vx);
            end
            else if (s2.x_hi)
            begin
                res_next.new_x     = {1'b0, s2.hx};
                res_next.new_vel_x = neg_abs(s2.rec.vx);
            end
            else
            begin
                res_next.new_x = s2.nx;
            end

            priority if (s2.y_lo)
            begin
                res_next.new_y     = 16'sd0;
                res_next.new_vel_y = abs_sat(s2.rec.vy);
            end
            else if (s2.y_hi)
            begin
                res_next.new_y     = {1'b0, s2.hy};
                res_next.new_vel_y = neg_abs(s2.rec.vy);
            end
            else
            begin
                res_next.new_y = s2.ny;
            end

            priority if (s2.z_lo)
            begin
                res_next.new_zoom      = s2.zmin;
                res_next.new_zoom_rate = abs_sat(s2.rec.zr);
            end
            else if (s2.z_hi)
            begin
                res_next.new_zoom      = s2.zmax;
                res_next.new_zoom_rate = neg_abs(s2.rec.zr);
            end
            else
            begin
                res_next.new_zoom = s2.nz;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
endmodule

// ----- sv/sprite_bounce_motion_update_unit.sv -----
// top level of the sprite bounce motion pipeline
//
//  channel   dir   handshake          contents
//  in_ch     in    valid / ready      one sprite transform record
//  out_ch    out   valid / ready      the record advanced by one frame
//  cfg       in    cfg_wr_en only     enable, frame size, zoom bounds
//
// three register stages (adders, compares, select); a record entering passes
// through all three before it shows on out_ch, one record per cycle while not stalled
// the whole pipe advances together, held only while out_ch has a result the
// sink does not take; nothing is dropped or repeated across a stall
// reset clears the stage valid bits and loads the register defaults
module sprite_bounce_motion_update_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    sbm_in_if.sink                            in_ch,
    sbm_out_if.source                         out_ch,
    input  logic                              cfg_wr_en,
    input  logic [sbm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sbm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import sbm_pkg::*;

    `include "assert_macros.svh"

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    in_rec_t in_rec;
    logic    pipe_en;
    logic    s1_valid;
    logic    s2_valid;
    logic    res_valid;
    s1_t     s1;
    s2_t     s2;
    res_t    res;
    logic [2:0] valid_all;
    logic    upd_out;

    // configuration registers, out-of-range indexes ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_UPDATE_ENABLE: cfg_next.update_enable = cfg_wdata[0];
                CFG_DISP_W:        cfg_next.disp_w        = cfg_wdata[14:0];
                CFG_DISP_H:        cfg_next.disp_h        = cfg_wdata[14:0];
                CFG_ZOOM_MINIMUM:  cfg_next.zoom_minimum  = cfg_wdata;
                CFG_ZOOM_MAXIMUM:  cfg_next.zoom_maximum  = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.update_enable <= 1'b0;
            cfg_reg.disp_w        <= 15'd0;
            cfg_reg.disp_h        <= 15'd0;
            cfg_reg.zoom_minimum  <= ZOOM_BOUND_RESET;
            cfg_reg.zoom_maximum  <= ZOOM_BOUND_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // pipe moves whenever the output register is empty or being drained
    assign pipe_en     = !res_valid || out_ch.ready;
    assign in_ch.ready = pipe_en;

    assign in_rec.resv   = in_ch.reserved_byte;
    assign in_rec.rec.x  = in_ch.pos_x;
    assign in_rec.rec.y  = in_ch.pos_y;
    assign in_rec.rec.vx = in_ch.vel_x;
    assign in_rec.rec.vy = in_ch.vel_y;
    assign in_rec.rec.ang = in_ch.angle;
    assign in_rec.rec.zm = in_ch.zoom;
    assign in_rec.rec.zr = in_ch.zoom_rate;
    assign in_rec.ar     = in_ch.angle_rate;
    assign in_rec.last   = in_ch.last_in_frame;

    // stage 1: validity check and sums
    sbm_sum_stage u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (in_ch.valid),
        .in_rec   (in_rec),
        .cfg      (cfg_reg),
        .s1_valid (s1_valid),
        .s1       (s1)
    );

    // stage 2: angle wrap and bounce compares
    sbm_cmp_stage u_cmp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .s1_valid (s1_valid),
        .s1       (s1),
        .cfg      (cfg_reg),
        .s2_valid (s2_valid),
        .s2       (s2)
    );

    // stage 3: clamp, reflect and hold the result for the sink
    sbm_sel_stage u_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .s2_valid  (s2_valid),
        .s2        (s2),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_ch.valid         = res_valid;
    assign out_ch.new_x         = res.new_x;
    assign out_ch.new_y         = res.new_y;
    assign out_ch.new_vel_x     = res.new_vel_x;
    assign out_ch.new_vel_y     = res.new_vel_y;
    assign out_ch.new_angle     = res.new_angle;
    assign out_ch.new_zoom      = res.new_zoom;
    assign out_ch.new_zoom_rate = res.new_zoom_rate;
    assign out_ch.was_updated   = res.was_updated;
    assign out_ch.last_out      = res.last_out;

    assign valid_all = {s1_valid, s2_valid, res_valid};
    assign upd_out   = out_ch.valid && out_ch.was_updated;

    // once reset has been seen at an edge, no result is presented
    `SBM_ASSERT_RST(a_no_valid_in_reset, !rst_n |=> !out_ch.valid, "result valid during reset")
    // an accepted record always lands in stage 1
    `SBM_ASSERT(a_accept_lands, (in_ch.valid && in_ch.ready) |=> s1_valid, "accepted record lost")
    // a stall freezes every stage valid bit
    `SBM_ASSERT(a_stall_freezes, !pipe_en |=> $stable(valid_all), "pipe moved during a stall")
    // updated angles are always wrapped into range
    `SBM_ASSERT(a_angle_wrapped, upd_out |-> out_ch.new_angle < 16'(ANGLE_WRAP), "bad angle")
    // updated positions never go negative
    `SBM_ASSERT(a_pos_nonneg, upd_out |-> !out_ch.new_x[15] && !out_ch.new_y[15], "x or y below 0")
endmodule
